FILE: src/rdt_pkg.sv
// ----------------------------------------------------------------------------
// rdt_pkg
// shared types and constants of the delivery tracker
// ----------------------------------------------------------------------------
package rdt_pkg;
  localparam int PendingDepthDef = 32;
  localparam int AckDepthDef     = 32;
  localparam logic [31:0] TimeoutReset = 32'd1000;

  localparam logic [2:0] KIND_SEND  = 3'd0;
  localparam logic [2:0] KIND_RECV  = 3'd1;
  localparam logic [2:0] KIND_ACK   = 3'd2;
  localparam logic [2:0] KIND_SCAN  = 3'd3;
  localparam logic [2:0] KIND_DRAIN = 3'd4;

  localparam logic [3:0] EV_ASSIGNED     = 4'd0;
  localparam logic [3:0] EV_ACCEPTED     = 4'd1;
  localparam logic [3:0] EV_OUT_OF_ORDER = 4'd2;
  localparam logic [3:0] EV_DELIVERED    = 4'd3;
  localparam logic [3:0] EV_ACK_UNKNOWN  = 4'd4;
  localparam logic [3:0] EV_TIMED_OUT    = 4'd5;
  localparam logic [3:0] EV_SCAN_DONE    = 4'd6;
  localparam logic [3:0] EV_ACK_COUNT    = 4'd7;
  localparam logic [3:0] EV_ACK_ENTRY    = 4'd8;
  localparam logic [3:0] EV_TABLE_FULL   = 4'd9;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] seq_number;
    logic [31:0] now_time;
    logic        has_delegate;
  } item_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [31:0] value;
    logic        notify;
    logic        ack_dropped;
    logic        last;
  } result_t;
endpackage

FILE: src/rdt_item_if.sv
// ----------------------------------------------------------------------------
// rdt_item_if
// valid/ready channel carrying one item beat
// ----------------------------------------------------------------------------
interface rdt_item_if import rdt_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/rdt_result_if.sv
// ----------------------------------------------------------------------------
// rdt_result_if
// valid/ready channel carrying one result beat
// ----------------------------------------------------------------------------
interface rdt_result_if import rdt_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/rdt_cfg_if.sv
// ----------------------------------------------------------------------------
// rdt_cfg_if
// valid/ready write channel for the timeout register
// ----------------------------------------------------------------------------
interface rdt_cfg_if ();
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/rdt_front.sv
// ----------------------------------------------------------------------------
// rdt_front
// accepts item beats, drops unused kinds, feeds a two-entry queue
// ----------------------------------------------------------------------------
module rdt_front import rdt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rdt_item_if.sink   in_ch,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);
  item_t      qmem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       push;
  logic       useful;

  assign useful = (in_ch.data.kind <= KIND_DRAIN);
  assign in_ch.ready = (fill != 2'd2);
  assign push = in_ch.valid && in_ch.ready && useful;
  assign q_valid = (fill != 2'd0);
  assign q_item = qmem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wptr] <= in_ch.data;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

FILE: src/rdt_back.sv
// ----------------------------------------------------------------------------
// rdt_back
// carries out queued items one at a time, walking the tables slot by slot
// ----------------------------------------------------------------------------
module rdt_back import rdt_pkg::*; #(
  parameter int PENDING_DEPTH = PendingDepthDef,
  parameter int ACK_DEPTH     = AckDepthDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  input  logic [31:0] timeout_ticks,
  output logic        busy,
  rdt_result_if.source out_ch
);
  localparam int PW = $clog2(PENDING_DEPTH);
  localparam int AW = $clog2(ACK_DEPTH);
  localparam int CW = $clog2(ACK_DEPTH + 1);
  localparam int SW = (PW > CW) ? PW : CW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WALK  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [PENDING_DEPTH-1:0] entry_valid;
  logic [31:0] entry_seq    [PENDING_DEPTH];
  logic [31:0] entry_time   [PENDING_DEPTH];
  logic        entry_notify [PENDING_DEPTH];
  logic [31:0] ack_queue    [ACK_DEPTH];
  logic [31:0] next_out_seq;
  logic [31:0] next_expected_seq;
  logic [CW-1:0] ack_count;

  logic [2:0]  state;
  item_t       cur;
  logic [SW-1:0] idx;
  logic        found;
  logic        held_notify;
  logic        any;
  logic [31:0] rd_seq;
  logic [31:0] rd_time;
  logic        rd_notify;
  logic        rd_valid;
  logic [31:0] ack_rd;
  logic        walk_end;
  logic        hold;
  logic        slot_hit;

  logic [PW-1:0] free_slot;
  logic          has_free;

  always_comb begin
    free_slot = '0;
    has_free = 1'b0;
    for (int i = PENDING_DEPTH - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        free_slot = PW'(i);
        has_free = 1'b1;
      end
    end
  end

  assign hold = out_ch.valid && !out_ch.ready;
  assign busy = (state != ST_IDLE) || q_valid;
  assign q_pop = (state == ST_IDLE) && q_valid && !hold;
  assign walk_end = (idx[PW-1:0] == PW'(PENDING_DEPTH - 1));
  assign slot_hit = entry_valid[idx[PW-1:0]]
      && ((cur.kind == KIND_ACK && rd_seq == cur.seq_number)
      || (cur.kind == KIND_SCAN && (cur.now_time - rd_time) >= timeout_ticks));

  always_ff @(posedge clk) begin
    rd_seq    <= entry_seq[idx[PW-1:0]];
    rd_time   <= entry_time[idx[PW-1:0]];
    rd_notify <= entry_notify[idx[PW-1:0]];
    ack_rd    <= ack_queue[idx[AW-1:0]];
    if (q_pop && q_item.kind == KIND_SEND && has_free) begin
      entry_seq[free_slot]    <= next_out_seq;
      entry_time[free_slot]   <= q_item.now_time;
      entry_notify[free_slot] <= q_item.has_delegate;
    end
    if (q_pop && q_item.kind == KIND_RECV && q_item.seq_number >= next_expected_seq
        && ack_count < CW'(ACK_DEPTH)) begin
      ack_queue[ack_count[AW-1:0]] <= q_item.seq_number;
    end
    if (rst) begin
      state <= ST_IDLE;
      entry_valid <= '0;
      next_out_seq <= '0;
      next_expected_seq <= '0;
      ack_count <= '0;
      out_ch.valid <= 1'b0;
      idx <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            cur <= q_item;
            idx <= '0;
            found <= 1'b0;
            any <= 1'b0;
            out_ch.data.ack_dropped <= 1'b0;
            out_ch.data.notify <= 1'b0;
            out_ch.data.last <= 1'b1;
            case (q_item.kind)
              KIND_SEND: begin
                out_ch.valid <= 1'b1;
                out_ch.data.value <= next_out_seq;
                if (has_free) begin
                  entry_valid[free_slot] <= 1'b1;
                  out_ch.data.event_res <= EV_ASSIGNED;
                  out_ch.data.notify <= q_item.has_delegate;
                  next_out_seq <= next_out_seq + 32'd1;
                end else begin
                  out_ch.data.event_res <= EV_TABLE_FULL;
                end
              end
              KIND_RECV: begin
                out_ch.valid <= 1'b1;
                out_ch.data.value <= q_item.seq_number;
                if (q_item.seq_number >= next_expected_seq) begin
                  out_ch.data.event_res <= EV_ACCEPTED;
                  next_expected_seq <= q_item.seq_number + 32'd1;
                  if (ack_count < CW'(ACK_DEPTH)) ack_count <= ack_count + CW'(1);
                  else out_ch.data.ack_dropped <= 1'b1;
                end else begin
                  out_ch.data.event_res <= EV_OUT_OF_ORDER;
                end
              end
              KIND_DRAIN: begin
                out_ch.valid <= 1'b1;
                out_ch.data.event_res <= EV_ACK_COUNT;
                out_ch.data.value <= 32'(ack_count);
                out_ch.data.last <= (ack_count == '0);
                if (ack_count != '0) state <= ST_DRAIN;
                rd_valid <= 1'b0;
              end
              default: begin
                state <= ST_WALK;
              end
            endcase
          end
        end
        ST_WALK: begin
          // registered read of slot idx lands next cycle
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!hold) begin
            if (slot_hit) begin
              entry_valid[idx[PW-1:0]] <= 1'b0;
              if (cur.kind == KIND_ACK) begin
                // a delivered beat is held back until the next hit or the walk end
                found <= 1'b1;
                held_notify <= rd_notify;
                if (found) begin
                  out_ch.valid <= 1'b1;
                  out_ch.data.event_res <= EV_DELIVERED;
                  out_ch.data.value <= cur.seq_number;
                  out_ch.data.notify <= held_notify;
                  out_ch.data.last <= 1'b0;
                end
              end else begin
                if (rd_notify) any <= 1'b1;
                out_ch.valid <= 1'b1;
                out_ch.data.event_res <= EV_TIMED_OUT;
                out_ch.data.value <= rd_seq;
                out_ch.data.notify <= rd_notify;
                out_ch.data.last <= 1'b0;
              end
            end
            if (walk_end) begin
              state <= ST_EMIT;
            end else begin
              idx <= idx + SW'(1);
              state <= ST_WALK;
            end
          end
        end
        ST_EMIT: begin
          if (!hold) begin
            out_ch.valid <= 1'b1;
            out_ch.data.last <= 1'b1;
            state <= ST_IDLE;
            if (cur.kind == KIND_ACK) begin
              out_ch.data.event_res <= found ? EV_DELIVERED : EV_ACK_UNKNOWN;
              out_ch.data.value <= cur.seq_number;
              out_ch.data.notify <= found && held_notify;
            end else begin
              out_ch.data.event_res <= EV_SCAN_DONE;
              out_ch.data.value <= '0;
              out_ch.data.notify <= any;
            end
          end
        end
        ST_DRAIN: begin
          if (!rd_valid) begin
            rd_valid <= 1'b1;
          end else if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.data.event_res <= EV_ACK_ENTRY;
            out_ch.data.value <= ack_rd;
            rd_valid <= 1'b0;
            if (CW'(idx) == ack_count - CW'(1)) begin
              out_ch.data.last <= 1'b1;
              ack_count <= '0;
              state <= ST_IDLE;
            end else begin
              idx <= idx + SW'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

FILE: src/reliable_delivery_tracker.sv
// ----------------------------------------------------------------------------
// reliable_delivery_tracker
// sequence and ack bookkeeping for reliable delivery over a lossy link
//
//   channel   role   beat
//   in_ch     sink   one item: kind, seq_number, now_time, has_delegate
//   out_ch    source one result: event_res, value, notify, ack_dropped, last
//   cfg_ch    sink   timeout_ticks write, taken only while nothing is in flight
//
// send and receive give their one beat straight from idle; ack and scan walk
// the pending table slot by slot, a read state then a check state per slot,
// then a closing beat; a drain gives one beat per queued ack after the count.
// the walk is set by the single registered read port of the table.
// reset is synchronous; the table holds no entries after reset.
// a stalled out_ch holds the walk; the front queue keeps taking items until its two entries are full.
// ----------------------------------------------------------------------------
module reliable_delivery_tracker import rdt_pkg::*; #(
  parameter int PENDING_DEPTH = PendingDepthDef,
  parameter int ACK_DEPTH     = AckDepthDef
) (
  input logic          clk,
  input logic          rst,
  rdt_item_if.sink     in_ch,
  rdt_result_if.source out_ch,
  rdt_cfg_if.sink      cfg_ch
);
  logic        q_valid;
  logic        q_pop;
  item_t       q_item;
  logic        busy;
  logic [31:0] timeout_ticks;

  assign cfg_ch.ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TimeoutReset;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      timeout_ticks <= cfg_ch.data;
    end
  end

  rdt_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  rdt_back #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .ACK_DEPTH     (ACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .timeout_ticks (timeout_ticks),
    .busy          (busy),
    .out_ch        (out_ch)
  );
endmodule

FILE: test/rdt_tracker_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdt_tracker_checker
// watches the item, result and timeout channels of the delivery tracker,
// keeps its own copy of the pending table and ack queue, works out the
// result beats of every accepted item and compares them in order
// ----------------------------------------------------------------------------
module rdt_tracker_checker import rdt_pkg::*; (
  input logic   clk,
  input logic   rst,
  rdt_item_if   in_ch,
  rdt_result_if out_ch,
  rdt_cfg_if    cfg_ch,
  output int    fail_count,
  output int    pending_beats
);
  localparam int Slots = PendingDepthDef;
  localparam int AckSlots = AckDepthDef;

  logic [31:0] timeout_q;
  logic [31:0] out_seq_q;
  logic [31:0] exp_seq_q;
  logic        slot_used[Slots];
  logic [31:0] slot_seq[Slots];
  logic [31:0] slot_time[Slots];
  logic        slot_notify[Slots];
  logic [31:0] acks[AckSlots];
  int          ack_fill;
  result_t     expected_beats[$];

  assign pending_beats = expected_beats.size();

  function automatic result_t mk(logic [3:0] ev, logic [31:0] val, logic nt, logic dr);
    result_t r;
    r.event_res = ev;
    r.value = val;
    r.notify = nt;
    r.ack_dropped = dr;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic track_item(item_t it);
    result_t res[$];
    int slot;
    logic any;
    slot = -1;
    any = 1'b0;
    case (it.kind)
      KIND_SEND: begin
        for (int i = 0; i < Slots; i++)
          if (!slot_used[i] && slot < 0) slot = i;
        if (slot < 0) begin
          res = {res, mk(EV_TABLE_FULL, out_seq_q, 1'b0, 1'b0)};
        end else begin
          slot_used[slot] = 1'b1;
          slot_seq[slot] = out_seq_q;
          slot_time[slot] = it.now_time;
          slot_notify[slot] = it.has_delegate;
          res = {res, mk(EV_ASSIGNED, out_seq_q, it.has_delegate, 1'b0)};
          out_seq_q = out_seq_q + 1;
        end
      end
      KIND_RECV: begin
        if (it.seq_number >= exp_seq_q) begin
          if (ack_fill < AckSlots) begin
            acks[ack_fill] = it.seq_number;
            ack_fill++;
            res = {res, mk(EV_ACCEPTED, it.seq_number, 1'b0, 1'b0)};
          end else begin
            res = {res, mk(EV_ACCEPTED, it.seq_number, 1'b0, 1'b1)};
          end
          exp_seq_q = it.seq_number + 1;
        end else begin
          res = {res, mk(EV_OUT_OF_ORDER, it.seq_number, 1'b0, 1'b0)};
        end
      end
      KIND_ACK: begin
        for (int i = 0; i < Slots; i++)
          if (slot_used[i] && slot_seq[i] == it.seq_number) begin
            slot_used[i] = 1'b0;
            res = {res, mk(EV_DELIVERED, it.seq_number, slot_notify[i], 1'b0)};
          end
        if (res.size() == 0) res = {res, mk(EV_ACK_UNKNOWN, it.seq_number, 1'b0, 1'b0)};
      end
      KIND_SCAN: begin
        for (int i = 0; i < Slots; i++)
          if (slot_used[i] && (it.now_time - slot_time[i]) >= timeout_q) begin
            slot_used[i] = 1'b0;
            any |= slot_notify[i];
            res = {res, mk(EV_TIMED_OUT, slot_seq[i], slot_notify[i], 1'b0)};
          end
        res = {res, mk(EV_SCAN_DONE, 32'd0, any, 1'b0)};
      end
      KIND_DRAIN: begin
        res = {res, mk(EV_ACK_COUNT, 32'(ack_fill), 1'b0, 1'b0)};
        for (int j = 0; j < ack_fill; j++) res = {res, mk(EV_ACK_ENTRY, acks[j], 1'b0, 1'b0)};
        ack_fill = 0;
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    expected_beats = {expected_beats, res};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      timeout_q = TimeoutReset;
      out_seq_q = '0;
      exp_seq_q = '0;
      ack_fill = 0;
      fail_count <= 0;
      for (int i = 0; i < Slots; i++) slot_used[i] = 1'b0;
      expected_beats.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) timeout_q = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) track_item(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat %p", out_ch.data);
          fail_count <= fail_count + 1;
        end else begin
          result_t e;
          result_t a;
          e = expected_beats.pop_front();
          a = out_ch.data;
          if (a !== e) begin
            fail_count <= fail_count + 1;
            if (a.event_res !== e.event_res)
              $error("event_res expected %0d actual %0d", e.event_res, a.event_res);
            if (a.value !== e.value)
              $error("value expected %0h actual %0h", e.value, a.value);
            if (a.notify !== e.notify)
              $error("notify expected %0b actual %0b", e.notify, a.notify);
            if (a.ack_dropped !== e.ack_dropped)
              $error("ack_dropped expected %0b actual %0b", e.ack_dropped, a.ack_dropped);
            if (a.last !== e.last)
              $error("last expected %0b actual %0b", e.last, a.last);
          end
        end
      end
    end
  end
endmodule

FILE: test/tb_reliable_delivery_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reliable_delivery_tracker
// drives directed and random send, receive, ack, scan, drain and unused-kind
// items with random gaps and output stalls, rewrites the timeout between
// phases and gives the verdict from the checker's failure count
// ----------------------------------------------------------------------------
module tb_reliable_delivery_tracker;
  import rdt_pkg::*;

  localparam int CycleLimit = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  int   fail_count;
  int   pending_beats;
  int   stall_left = 0;
  bit   calm = 1'b0;
  logic [31:0] clock_ticks = 32'd0;
  logic [31:0] sent_hi = 32'd0;

  rdt_item_if   in_ch ();
  rdt_result_if out_ch ();
  rdt_cfg_if    cfg_ch ();

  reliable_delivery_tracker dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  rdt_tracker_checker checker_u (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending_beats(pending_beats)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // output stalls in bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 14);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_item(logic [2:0] k, logic [31:0] s, logic [31:0] t, logic d);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{kind: k, seq_number: s, now_time: t, has_delegate: d};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic set_timeout(logic [31:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_item();
    int pick;
    logic [31:0] s;
    pick = $urandom_range(0, 99);
    clock_ticks = clock_ticks + $urandom_range(0, 400);
    if (pick < 30) begin
      push_item(KIND_SEND, $urandom, clock_ticks, 1'($urandom_range(0, 1)));
      sent_hi = sent_hi + 1;
    end else if (pick < 55) begin
      s = ($urandom_range(0, 3) == 0) ? $urandom : sent_hi + $urandom_range(0, 3);
      push_item(KIND_RECV, s, $urandom, 1'($urandom_range(0, 1)));
    end else if (pick < 78) begin
      s = ($urandom_range(0, 5) == 0) ? $urandom : sent_hi - $urandom_range(1, 40);
      push_item(KIND_ACK, s, $urandom, 1'($urandom_range(0, 1)));
    end else if (pick < 88) begin
      push_item(KIND_SCAN, $urandom, clock_ticks, 1'($urandom_range(0, 1)));
    end else if (pick < 97) begin
      push_item(KIND_DRAIN, $urandom, $urandom, 1'($urandom_range(0, 1)));
    end else begin
      push_item(3'($urandom_range(5, 7)), $urandom, $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, full table, duplicates, wrap, queue overflow
    push_item(KIND_DRAIN, 32'd0, 32'd0, 1'b0);
    push_item(KIND_RECV, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    push_item(KIND_RECV, 32'd0, 32'd0, 1'b0);
    push_item(KIND_RECV, 32'd0, 32'd0, 1'b0);
    push_item(KIND_ACK, 32'hFFFF_FFFF, 32'd0, 1'b0);
    for (int i = 0; i < 34; i++)
      push_item(KIND_SEND, 32'd0, 32'hFFFF_FFF0 + i, i[0]);
    push_item(KIND_ACK, 32'd3, 32'd0, 1'b0);
    push_item(KIND_SCAN, 32'd0, 32'hFFFF_FFF8, 1'b0);
    push_item(KIND_SCAN, 32'd0, 32'd1500, 1'b0);
    for (int i = 0; i < 34; i++)
      push_item(KIND_RECV, 32'd10 + i, 32'd0, 1'b0);
    push_item(KIND_DRAIN, 32'd0, 32'd0, 1'b0);
    push_item(3'd6, 32'd0, 32'd0, 1'b0);
    sent_hi = 32'd34;
    set_timeout(32'd0);
    push_item(KIND_SEND, 32'd0, 32'd5, 1'b1);
    push_item(KIND_SCAN, 32'd0, 32'd5, 1'b0);
    set_timeout(32'hFFFF_FFFF);
    push_item(KIND_SEND, 32'd0, 32'd5, 1'b1);
    push_item(KIND_SCAN, 32'd0, 32'd4, 1'b0);
    push_item(KIND_ACK, 32'd35, 32'd0, 1'b0);
    sent_hi = 32'd36;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_timeout(32'd1);
        1: set_timeout(32'd2000);
        2: set_timeout($urandom_range(100, 5000));
        default: set_timeout(32'd1000);
      endcase
      if (ph == 3) calm = 1'b1;
      for (int n = 0; n < 87; n++) random_item();
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: reliable_delivery_tracker.f
src/rdt_pkg.sv
src/rdt_item_if.sv
src/rdt_result_if.sv
src/rdt_cfg_if.sv
src/rdt_front.sv
src/rdt_back.sv
src/reliable_delivery_tracker.sv
test/rdt_tracker_checker.sv
test/tb_reliable_delivery_tracker.sv
